// ===== hdl/dll_pkg.sv =====
// Shared constants, types and helper functions for the linked list engine.
`default_nettype none

package dll_pkg;

    localparam int NODE_SLOTS = 64;
    localparam int SLOT_W     = $clog2(NODE_SLOTS);
    localparam int LINK_W     = $clog2(NODE_SLOTS + 1);
    localparam int CNT_W      = LINK_W;

    localparam int OP_W       = 3;
    localparam int NODE_W     = 6;
    localparam int WALK_W     = 10;
    localparam int NCOUNT_W   = 7;

    // input request: operation, node, walk_index from bit 0 up, padded to bytes
    localparam int S_FIELD_W  = OP_W + NODE_W + WALK_W;
    localparam int S_TDATA_W  = ((S_FIELD_W + 7) / 8) * 8;
    // result: result_node, node_count, status from bit 0 up, padded to bytes
    localparam int M_FIELD_W  = NODE_W + NCOUNT_W + 1;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 3'd0,
        OP_APPEND  = 3'd1,
        OP_PREPEND = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_NEXT    = 3'd4,
        OP_PREV    = 3'd5,
        OP_NTH     = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REMOVE,
        ST_STEP,
        ST_WALK,
        ST_LINK,
        ST_DONE
    } state_t;

    localparam link_t LINK_NULL = '0;

    // link code: zero is null, otherwise slot + 1
    function automatic slot_t link_to_slot(input link_t link);
        link_t dec;
        dec = link - LINK_W'(1);
        return slot_t'(dec);
    endfunction

    function automatic link_t slot_to_link(input slot_t slot);
        return link_t'(slot) + LINK_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/doubly_linked_list_engine_core.sv =====
// Top level of the doubly linked list engine: control, link memories and result register.
`default_nettype none

// Path from the accepting edge to m_tvalid: clear, rejects, unused codes, an insert into an empty
// list, nth on an empty list and a step from null or a non-member go from ST_EXEC to ST_DONE;
// other inserts pass ST_LINK, remove ST_REMOVE and a step from a member ST_STEP; nth steps
// walk_index times from the head in ST_WALK (one read per step). One request in flight; the next
// is taken in the cycle after the result moves to the output register, so output stalls hold it up.
// Reset (aresetn low, synchronous) empties the list and clears every membership bit.
module doubly_linked_list_engine_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: operation [2:0], node [8:3], walk_index [18:9], zero pad
    input  logic [dll_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: from_null
    input  logic                            s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m_tdata: result_node [5:0], node_count [12:6], status [13], zero pad
    output logic [dll_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: result_valid
    output logic                            m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import dll_pkg::*;

    // ---------------------------------------------------------------
    // Request and list state
    // ---------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [OP_W-1:0]        req_op_reg, req_op_next;
    logic [NODE_W-1:0]      req_node_reg, req_node_next;
    logic                   req_null_reg, req_null_next;
    logic [WALK_W-1:0]      req_walk_reg, req_walk_next;

    slot_t                  head_reg, head_next;
    slot_t                  tail_reg, tail_next;
    count_t                 count_reg, count_next;
    logic [NODE_SLOTS-1:0]  member_reg, member_next;

    // nth walk: remaining steps and current position
    logic [WALK_W-1:0]      rem_reg, rem_next;
    link_t                  cur_reg, cur_next;
    logic                   use_rd_reg, use_rd_next;
    link_t                  cur_sel;

    // pending result
    slot_t                  res_slot_reg, res_slot_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   res_status_reg, res_status_next;

    // output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [NODE_W-1:0]      m_node_reg, m_node_next;
    logic [NCOUNT_W-1:0]    m_count_reg, m_count_next;
    logic                   m_status_reg, m_status_next;
    logic                   m_rvalid_reg, m_rvalid_next;

    // ---------------------------------------------------------------
    // Link memories: one write and one read port each, registered read
    // ---------------------------------------------------------------
    link_t                  next_mem [NODE_SLOTS];
    link_t                  prev_mem [NODE_SLOTS];
    logic                   next_we, prev_we;
    slot_t                  next_wa, prev_wa;
    link_t                  next_wd, prev_wd;
    slot_t                  rd_addr;
    link_t                  next_rd_reg, prev_rd_reg;

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        next_rd_reg <= next_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_rd_reg <= prev_mem[rd_addr];
    end

    // ---------------------------------------------------------------
    // Decode of the held request
    // ---------------------------------------------------------------
    slot_t  req_slot;
    logic   req_in_range;
    logic   req_member;
    logic   out_free;

    assign req_slot     = slot_t'(req_node_reg);
    assign req_in_range = 32'(req_node_reg) < 32'(NODE_SLOTS);
    assign req_member   = req_in_range && member_reg[req_slot];
    assign out_free     = !m_tvalid_reg || m_tready;
    assign cur_sel      = use_rd_reg ? next_rd_reg : cur_reg;

    assign s_tready = (state_reg == ST_IDLE);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            member_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            member_reg   <= member_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_op_reg     <= req_op_next;
        req_node_reg   <= req_node_next;
        req_null_reg   <= req_null_next;
        req_walk_reg   <= req_walk_next;
        rem_reg        <= rem_next;
        cur_reg        <= cur_next;
        use_rd_reg     <= use_rd_next;
        res_slot_reg   <= res_slot_next;
        res_valid_reg  <= res_valid_next;
        res_status_reg <= res_status_next;
        m_node_reg     <= m_node_next;
        m_count_reg    <= m_count_next;
        m_status_reg   <= m_status_next;
        m_rvalid_reg   <= m_rvalid_next;
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        req_op_next     = req_op_reg;
        req_node_next   = req_node_reg;
        req_null_next   = req_null_reg;
        req_walk_next   = req_walk_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        member_next     = member_reg;
        rem_next        = rem_reg;
        cur_next        = cur_reg;
        use_rd_next     = use_rd_reg;
        res_slot_next   = res_slot_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_node_next     = m_node_reg;
        m_count_next    = m_count_reg;
        m_status_next   = m_status_reg;
        m_rvalid_next   = m_rvalid_reg;

        next_we = 1'b0;
        next_wa = req_slot;
        next_wd = LINK_NULL;
        prev_we = 1'b0;
        prev_wa = req_slot;
        prev_wd = LINK_NULL;
        rd_addr = req_slot;

        case (state_reg)
            ST_IDLE: begin
                // latch the request
                if (s_tvalid) begin
                    req_op_next   = s_tdata[OP_W-1:0];
                    req_node_next = s_tdata[OP_W +: NODE_W];
                    req_walk_next = s_tdata[OP_W+NODE_W +: WALK_W];
                    req_null_next = s_tuser;
                    state_next    = ST_EXEC;
                end
            end

            ST_EXEC: begin
                // default: a null result, status ok, finish now
                res_slot_next   = '0;
                res_valid_next  = 1'b0;
                res_status_next = 1'b0;
                state_next      = ST_DONE;
                case (op_t'(req_op_reg))
                    OP_CLEAR: begin
                        head_next   = '0;
                        tail_next   = '0;
                        count_next  = '0;
                        member_next = '0;
                    end
                    OP_APPEND, OP_PREPEND: begin
                        if (req_member || !req_in_range) begin
                            res_status_next = 1'b1;
                        end else begin
                            member_next[req_slot] = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            next_we = 1'b1;
                            prev_we = 1'b1;
                            if (count_reg == '0) begin
                                head_next = req_slot;
                                tail_next = req_slot;
                            end else if (op_t'(req_op_reg) == OP_APPEND) begin
                                prev_wd    = slot_to_link(tail_reg);
                                state_next = ST_LINK;
                            end else begin
                                next_wd    = slot_to_link(head_reg);
                                state_next = ST_LINK;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (!req_member) begin
                            res_status_next = 1'b1;
                        end else begin
                            state_next = ST_REMOVE;
                        end
                    end
                    OP_NEXT, OP_PREV: begin
                        if (req_null_reg) begin
                            if (count_reg != '0) begin
                                res_valid_next = 1'b1;
                                res_slot_next  = (op_t'(req_op_reg) == OP_NEXT) ?
                                                 head_reg : tail_reg;
                            end
                        end else if (req_member) begin
                            state_next = ST_STEP;
                        end
                    end
                    OP_NTH: begin
                        if (count_reg != '0) begin
                            cur_next    = slot_to_link(head_reg);
                            use_rd_next = 1'b0;
                            rem_next    = req_walk_reg;
                            state_next  = ST_WALK;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            ST_LINK: begin
                // second link write of an insert into a non-empty list
                if (op_t'(req_op_reg) == OP_APPEND) begin
                    next_we   = 1'b1;
                    next_wa   = tail_reg;
                    next_wd   = slot_to_link(req_slot);
                    tail_next = req_slot;
                end else begin
                    prev_we   = 1'b1;
                    prev_wa   = head_reg;
                    prev_wd   = slot_to_link(req_slot);
                    head_next = req_slot;
                end
                state_next = ST_DONE;
            end

            ST_REMOVE: begin
                // neighbors arrived from the read issued in ST_EXEC; splice them
                if (prev_rd_reg != LINK_NULL) begin
                    next_we = 1'b1;
                    next_wa = link_to_slot(prev_rd_reg);
                    next_wd = next_rd_reg;
                end else begin
                    head_next = (next_rd_reg != LINK_NULL) ? link_to_slot(next_rd_reg) : '0;
                end
                if (next_rd_reg != LINK_NULL) begin
                    prev_we = 1'b1;
                    prev_wa = link_to_slot(next_rd_reg);
                    prev_wd = prev_rd_reg;
                end else begin
                    tail_next = (prev_rd_reg != LINK_NULL) ? link_to_slot(prev_rd_reg) : '0;
                end
                member_next[req_slot] = 1'b0;
                if (count_reg != '0) begin
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = ST_DONE;
            end

            ST_STEP: begin
                if (op_t'(req_op_reg) == OP_NEXT) begin
                    res_valid_next = (next_rd_reg != LINK_NULL);
                    res_slot_next  = link_to_slot(next_rd_reg);
                end else begin
                    res_valid_next = (prev_rd_reg != LINK_NULL);
                    res_slot_next  = link_to_slot(prev_rd_reg);
                end
                state_next = ST_DONE;
            end

            ST_WALK: begin
                // one step per cycle; null wraps back to the head
                rd_addr = link_to_slot(cur_sel);
                if (rem_reg == '0) begin
                    res_valid_next = (cur_sel != LINK_NULL);
                    res_slot_next  = link_to_slot(cur_sel);
                    state_next     = ST_DONE;
                end else begin
                    rem_next = rem_reg - WALK_W'(1);
                    if (cur_sel == LINK_NULL) begin
                        cur_next    = slot_to_link(head_reg);
                        use_rd_next = 1'b0;
                    end else begin
                        use_rd_next = 1'b1;
                    end
                end
            end

            ST_DONE: begin
                // hand the result to the output register once it is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_node_next   = res_valid_reg ? NODE_W'(res_slot_reg) : '0;
                    m_rvalid_next = res_valid_reg;
                    m_count_next  = NCOUNT_W'(count_reg);
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_rvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_status_reg, m_count_reg, m_node_reg});

endmodule

`default_nettype wire

// ===== hdl/dll_checker.sv =====
// Port-level checker for the linked list engine and its bind to the top level.
`default_nettype none

module dll_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [dll_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready
);
    import dll_pkg::*;

    localparam int CNT_LO  = NODE_W;
    localparam int STAT_AT = NODE_W + NCOUNT_W;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    // a rejected request never names a node
    a_reject_null: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[STAT_AT] |-> !m_tuser)
        else $error("rejected request carries a node result");

    // a found node implies a non-empty list
    a_found_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[CNT_LO +: NCOUNT_W] != '0)
        else $error("node result from an empty list");

    // node count stays within the pool
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[CNT_LO +: NCOUNT_W]) <= 32'(NODE_SLOTS))
        else $error("node count beyond pool size");

    // a null result carries node zero
    a_null_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[NODE_W-1:0] == '0)
        else $error("null result with nonzero node");

endmodule

bind doubly_linked_list_engine_core dll_checker u_dll_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
